@@ src/tcce_pkg.sv @@
// Package for the text console cursor and escape controller.
// Holds the transaction structs, the action and register codes and the control characters.
// No dependencies.
package tcce_pkg;

   // Display actions reported with each result
   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_DRAW  = 2'd1,
      ACT_ERASE = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   // Request operations
   typedef enum logic {
      OP_PUT_CHAR   = 1'b0,
      OP_SET_CURSOR = 1'b1
   } op_type;

   // Register indexes on the configuration port
   localparam logic [7:0] CSR_LAST_COLUMN   = 8'd0;
   localparam logic [7:0] CSR_LAST_ROW      = 8'd1;
   localparam logic [7:0] CSR_COLUMN_OFFSET = 8'd2;
   localparam logic [7:0] CSR_ROW_OFFSET    = 8'd3;

   // Register reset values
   localparam logic [7:0] LAST_COLUMN_RST = 8'd79;
   localparam logic [7:0] LAST_ROW_RST    = 8'd24;
   localparam logic [3:0] COLOR_DEFAULT   = 4'd10;

   // Control characters
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_SEMI  = 8'd59;
   localparam logic [7:0] CH_OPEN  = 8'd91;
   localparam logic [7:0] CH_CLOSE = 8'd93;
   localparam logic [3:0] DIGIT_HI = 4'h3;
   localparam logic [3:0] DIGIT_MAX = 4'd9;

   localparam logic [7:0] ROW_MAX = 8'd255;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
      logic [7:0] new_column;
      logic [7:0] new_row;
   } req_type;

   typedef struct packed {
      action_type action;
      logic [8:0] display_column;
      logic [8:0] display_row;
      logic [7:0] glyph;
      logic [3:0] color_code;
      logic [7:0] cursor_column;
      logic [7:0] cursor_row;
   } rsp_type;

endpackage

@@ src/text_console_cursor_escape.sv @@
// Top level of the text console cursor and escape controller.
// Depends on tcce_pkg for the transaction structs, action codes and characters.
//
// Takes one transaction per clock: a character to place on the console or a
// set-cursor request. The cursor, the colour escape flags (ESC [ digit ] ;)
// and the colour code are updated at acceptance, and one result with the
// display action, the offset cell address, the glyph, the colour code and the
// new cursor is presented in the output register on the next cycle. A request
// is accepted every cycle unless the output register holds a result that the
// sink is stalling; each result is held in the single result register.
// Configuration registers are written through the csr_ port, which is always
// ready; indexes beyond the register list are ignored.
module text_console_cursor_escape
   import tcce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_wdata
);

   logic [7:0] last_column_ff, last_row_ff, column_offset_ff, row_offset_ff;
   logic [7:0] cursor_col_ff, cursor_col_in;
   logic [7:0] cursor_line_ff, cursor_line_in;
   logic [3:0] current_color_ff, current_color_in;
   logic [3:0] pending_digit_ff, pending_digit_in;
   logic       seen_escape_ff, seen_escape_in;
   logic       seen_open_ff, seen_open_in;
   logic       seen_digit_ff, seen_digit_in;
   logic       seen_close_ff, seen_close_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       req_accept;
   logic [7:0] ch;
   logic       is_digit;
   logic [7:0] wrap_col, wrap_line;

   // Output register frees up when empty or being taken this cycle
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign ch       = req_data.char_code;
   assign is_digit = (ch[7:4] == DIGIT_HI) && (ch[3:0] <= DIGIT_MAX);

   // Printable character: wrap at the last column first
   always_comb begin
      if (cursor_col_ff >= last_column_ff) begin
         wrap_col  = 8'd0;
         wrap_line = (cursor_line_ff == ROW_MAX) ? ROW_MAX : cursor_line_ff + 8'd1;
      end else begin
         wrap_col  = cursor_col_ff;
         wrap_line = cursor_line_ff;
      end
   end

   // Next cursor, escape state and result
   always_comb begin
      cursor_col_in    = cursor_col_ff;
      cursor_line_in   = cursor_line_ff;
      current_color_in = current_color_ff;
      pending_digit_in = pending_digit_ff;
      seen_escape_in   = seen_escape_ff;
      seen_open_in     = seen_open_ff;
      seen_digit_in    = seen_digit_ff;
      seen_close_in    = seen_close_ff;
      rsp_data_in      = '0;
      rsp_data_in.action = ACT_NONE;

      if (req_data.op == OP_SET_CURSOR) begin
         if (req_data.new_column <= last_column_ff) cursor_col_in = req_data.new_column;
         if (req_data.new_row <= last_row_ff) cursor_line_in = req_data.new_row;
      end else if (ch == CH_NL) begin
         cursor_col_in  = 8'd0;
         cursor_line_in = (cursor_line_ff == ROW_MAX) ? ROW_MAX : cursor_line_ff + 8'd1;
      end else if (ch == CH_CR) begin
         cursor_col_in = 8'd0;
      end else if (ch == CH_BS) begin
         if (cursor_col_ff != 8'd0) begin
            cursor_col_in = cursor_col_ff - 8'd1;
         end else if (cursor_line_ff != 8'd0) begin
            cursor_line_in = cursor_line_ff - 8'd1;
            cursor_col_in  = last_column_ff;
         end
         rsp_data_in.action         = ACT_ERASE;
         rsp_data_in.display_column = {1'b0, cursor_col_in} + {1'b0, column_offset_ff};
         rsp_data_in.display_row    = {1'b0, cursor_line_in} + {1'b0, row_offset_ff};
      end else if (ch == CH_ESC) begin
         seen_escape_in = 1'b1;
      end else if (ch == CH_OPEN && seen_escape_ff) begin
         seen_open_in = 1'b1;
      end else if (is_digit && seen_escape_ff && seen_open_ff) begin
         seen_digit_in    = 1'b1;
         pending_digit_in = ch[3:0];
      end else if (ch == CH_CLOSE && seen_escape_ff && seen_open_ff && seen_digit_ff) begin
         seen_close_in = 1'b1;
      end else if (ch == CH_SEMI && seen_escape_ff && seen_open_ff && seen_digit_ff
                   && seen_close_ff) begin
         current_color_in = pending_digit_ff;
      end else begin
         // Printable: draw, or clear and home when at or past the last row
         if (wrap_line >= last_row_ff) begin
            rsp_data_in.action = ACT_CLEAR;
            cursor_col_in      = 8'd0;
            cursor_line_in     = 8'd0;
         end else begin
            rsp_data_in.action         = ACT_DRAW;
            rsp_data_in.display_column = {1'b0, wrap_col} + {1'b0, column_offset_ff};
            rsp_data_in.display_row    = {1'b0, wrap_line} + {1'b0, row_offset_ff};
            rsp_data_in.glyph          = ch;
            cursor_col_in              = wrap_col + 8'd1;
            cursor_line_in             = wrap_line;
         end
         seen_escape_in   = 1'b0;
         seen_open_in     = 1'b0;
         seen_digit_in    = 1'b0;
         seen_close_in    = 1'b0;
         pending_digit_in = 4'd0;
      end

      rsp_data_in.color_code    = current_color_in;
      rsp_data_in.cursor_column = cursor_col_in;
      rsp_data_in.cursor_row    = cursor_line_in;
   end

   // Result register handshake
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         cursor_col_ff    <= 8'd0;
         cursor_line_ff   <= 8'd0;
         current_color_ff <= COLOR_DEFAULT;
         pending_digit_ff <= 4'd0;
         seen_escape_ff   <= 1'b0;
         seen_open_ff     <= 1'b0;
         seen_digit_ff    <= 1'b0;
         seen_close_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            cursor_col_ff    <= cursor_col_in;
            cursor_line_ff   <= cursor_line_in;
            current_color_ff <= current_color_in;
            pending_digit_ff <= pending_digit_in;
            seen_escape_ff   <= seen_escape_in;
            seen_open_ff     <= seen_open_in;
            seen_digit_ff    <= seen_digit_in;
            seen_close_ff    <= seen_close_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_column_ff   <= LAST_COLUMN_RST;
         last_row_ff      <= LAST_ROW_RST;
         column_offset_ff <= 8'd0;
         row_offset_ff    <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LAST_COLUMN:   last_column_ff   <= csr_wdata;
            CSR_LAST_ROW:      last_row_ff      <= csr_wdata;
            CSR_COLUMN_OFFSET: column_offset_ff <= csr_wdata;
            CSR_ROW_OFFSET:    row_offset_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule
